// ----- hw/rtl/cbspl_pkg.sv -----
// Shared types and constants for the cubic B-spline point generator.
// No dependencies.
`default_nettype none
package cbspl_pkg;
   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_STEP  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam int unsigned CSR_T_STEP = 0;
   localparam int unsigned TSTEP_RESET = 66;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_CLEAR,
      OP_STEP,
      OP_NONE
   } op_type;
endpackage
`default_nettype wire

// ----- hw/rtl/cbspl_front.sv -----
// Front end: command decode feeding a two-entry queue.
// Depends on cbspl_pkg.
`default_nettype none
module cbspl_front import cbspl_pkg::*; #(
   parameter int CB = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic [1:0]    req_mode,
   input  wire logic [CB-1:0] req_point_x,
   input  wire logic [CB-1:0] req_point_y,
   output logic               q_valid,
   input  wire logic          q_take,
   output op_type             q_op,
   output logic [CB-1:0]      q_x,
   output logic [CB-1:0]      q_y
);
   op_type          op_ff [2];
   logic [CB-1:0]   x_ff [2];
   logic [CB-1:0]   y_ff [2];
   logic [1:0]      cnt_ff, cnt_in;
   logic            rd_ff, wr_ff;
   op_type          dec;
   logic            acc;

   always_comb begin
      case (req_mode)
         MODE_PUSH:  dec = OP_PUSH;
         MODE_STEP:  dec = OP_STEP;
         MODE_CLEAR: dec = OP_CLEAR;
         default:    dec = OP_NONE;
      endcase
   end

   assign req_full = (cnt_ff == 2'd2);
   assign acc      = req_push && !req_full && dec != OP_NONE;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_op     = op_ff[rd_ff];
   assign q_x      = x_ff[rd_ff];
   assign q_y      = y_ff[rd_ff];
   assign cnt_in   = cnt_ff + {1'b0, acc} - {1'b0, q_take && q_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (acc) begin
            wr_ff <= !wr_ff;
         end
         if (q_take && q_valid) begin
            rd_ff <= !rd_ff;
         end
      end
      if (acc) begin
         op_ff[wr_ff] <= dec;
         x_ff[wr_ff]  <= req_point_x;
         y_ff[wr_ff]  <= req_point_y;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/cbspl_back.sv -----
// Back end: window state and a sequenced evaluator whose states use their own multipliers.
// Depends on cbspl_pkg.
`default_nettype none
module cbspl_back import cbspl_pkg::*; #(
   parameter int CB = 12,
   parameter int TF = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [TF:0]   t_step,
   input  wire logic          q_valid,
   output logic               q_take,
   input  wire op_type        q_op,
   input  wire logic [CB-1:0] q_x,
   input  wire logic [CB-1:0] q_y,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic [CB-1:0]      rsp_pixel_x,
   output logic [CB-1:0]      rsp_pixel_y,
   output logic               rsp_status,
   output logic               rsp_segment_last
);
   localparam int WB  = 3*TF + 4;
   localparam int AB  = WB + CB + 3;
   localparam int QB  = AB - 3*TF;
   localparam int DK  = QB + 2;
   localparam int DM  = ((1 << DK) + 5) / 6;

   typedef enum logic [2:0] {
      S_IDLE, S_T2, S_T3, S_U2, S_U3, S_MAC, S_DIV, S_OUT
   } state_type;

   state_type                 st_ff;
   logic signed [CB-1:0]      wx_ff [4];
   logic signed [CB-1:0]      wy_ff [4];
   logic [2:0]                held_ff;
   logic [TF:0]               t_ff;
   logic                      done_ff;
   logic [3*TF+2:0]           t2_ff, t3_ff, u2_ff, u3_ff;
   logic [WB-1:0]             w_ff [4];
   logic [2:0]                k_ff;
   logic signed [AB-1:0]      ax_ff, ay_ff;
   logic [QB-1:0]             qx_ff, qy_ff;
   logic                      nx_ff, ny_ff, last_ff;
   logic                      ov_ff;
   logic [CB-1:0]             ox_ff, oy_ff;
   logic                      os_ff, ol_ff;
   logic [TF+1:0]             nxt;
   logic [TF:0]               stp;
   logic [TF:0]               uu;
   logic [3*TF+2:0]           s3, t2s, ts2;
   logic [WB-1:0]             wsel;
   logic signed [WB+CB:0]     px, py;
   logic [QB-1:0]             magx, magy;

   assign stp   = (t_step == '0) ? {{TF{1'b0}}, 1'b1} : t_step;
   assign nxt   = {1'b0, t_ff} + {1'b0, stp};
   assign uu    = (TF+1)'(1 << TF) - t_ff;
   assign s3    = (3*TF+3)'(1) << (3*TF);
   assign t2s   = t2_ff << TF;
   assign ts2   = (3*TF+3)'(t_ff) << (2*TF);
   assign wsel  = w_ff[k_ff[1:0]];
   assign px    = $signed({1'b0, wsel}) * wx_ff[k_ff[1:0]];
   assign py    = $signed({1'b0, wsel}) * wy_ff[k_ff[1:0]];
   assign magx  = ax_ff[AB-1] ? QB'((-ax_ff) >>> (3*TF)) : QB'(ax_ff >>> (3*TF));
   assign magy  = ay_ff[AB-1] ? QB'((-ay_ff) >>> (3*TF)) : QB'(ay_ff >>> (3*TF));
   assign q_take = q_valid && st_ff == S_IDLE && !(q_op == OP_STEP && ov_ff);
   assign rsp_empty        = !ov_ff;
   assign rsp_pixel_x      = ox_ff;
   assign rsp_pixel_y      = oy_ff;
   assign rsp_status       = os_ff;
   assign rsp_segment_last = ol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         held_ff <= '0;
         t_ff    <= '0;
         done_ff <= 1'b0;
         ov_ff   <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            wx_ff[i] <= '0;
            wy_ff[i] <= '0;
         end
      end else begin
         if (rsp_pop && ov_ff) begin
            ov_ff <= 1'b0;
         end
         case (st_ff)
            S_IDLE: begin
               if (q_take) begin
                  case (q_op)
                     OP_PUSH: begin
                        for (int i = 0; i < 3; i++) begin
                           wx_ff[i] <= wx_ff[i+1];
                           wy_ff[i] <= wy_ff[i+1];
                        end
                        wx_ff[3] <= q_x;
                        wy_ff[3] <= q_y;
                        if (held_ff != 3'd4) begin
                           held_ff <= held_ff + 3'd1;
                        end
                        t_ff    <= '0;
                        done_ff <= 1'b0;
                     end
                     OP_CLEAR: begin
                        for (int i = 0; i < 4; i++) begin
                           wx_ff[i] <= '0;
                           wy_ff[i] <= '0;
                        end
                        held_ff <= '0;
                        t_ff    <= '0;
                        done_ff <= 1'b0;
                     end
                     OP_STEP: begin
                        if (held_ff != 3'd4 || done_ff) begin
                           ov_ff <= 1'b1;
                           ox_ff <= '0;
                           oy_ff <= '0;
                           os_ff <= 1'b1;
                           ol_ff <= 1'b0;
                        end else begin
                           t2_ff <= (3*TF+3)'(t_ff * t_ff);
                           st_ff <= S_T2;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_T2: begin
               t3_ff <= (3*TF+3)'(t2_ff[2*TF:0] * t_ff);
               u2_ff <= (3*TF+3)'(uu * uu);
               st_ff <= S_T3;
            end
            S_T3: begin
               u3_ff <= (3*TF+3)'(u2_ff[2*TF:0] * uu);
               st_ff <= S_U2;
            end
            S_U2: begin
               w_ff[0] <= WB'(u3_ff);
               w_ff[1] <= WB'(3*t3_ff) + WB'(4*s3) - WB'(6*t2s);
               w_ff[2] <= WB'(3*t2s) + WB'(3*ts2) + WB'(s3) - WB'(3*t3_ff);
               w_ff[3] <= WB'(t3_ff);
               k_ff    <= '0;
               ax_ff   <= '0;
               ay_ff   <= '0;
               last_ff <= nxt > (TF+2)'(1 << TF);
               st_ff   <= S_MAC;
            end
            S_MAC: begin
               ax_ff <= ax_ff + AB'(px);
               ay_ff <= ay_ff + AB'(py);
               k_ff  <= k_ff + 3'd1;
               if (k_ff == 3'd3) begin
                  st_ff <= S_U3;
               end
            end
            S_U3: begin
               qx_ff <= magx;
               qy_ff <= magy;
               nx_ff <= ax_ff[AB-1];
               ny_ff <= ay_ff[AB-1];
               st_ff <= S_DIV;
            end
            S_DIV: begin
               qx_ff <= QB'(((2*QB)'(qx_ff) * (2*QB)'(DM)) >> DK);
               qy_ff <= QB'(((2*QB)'(qy_ff) * (2*QB)'(DM)) >> DK);
               st_ff <= S_OUT;
            end
            S_OUT: begin
               if (!ov_ff) begin
                  ov_ff <= 1'b1;
                  ox_ff <= nx_ff ? CB'(-qx_ff) : CB'(qx_ff);
                  oy_ff <= ny_ff ? CB'(-qy_ff) : CB'(qy_ff);
                  os_ff <= 1'b0;
                  ol_ff <= last_ff;
                  if (last_ff) begin
                     done_ff <= 1'b1;
                  end else begin
                     t_ff <= nxt[TF:0];
                  end
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/cubic_bspline_point_generator.sv -----
// Uniform cubic B-spline point generator. Once a step item leaves the queue, the
// idle state forms t^2, S_T2 forms t^3 and (1-t)^2 and S_T3 forms (1-t)^3. S_U2
// builds the basis weights, S_MAC multiply-accumulates the four window points, S_U3
// shifts, S_DIV divides by six with a reciprocal multiply and S_OUT loads the result,
// which then waits for pop; a step behind an unread result holds. Push and clear
// complete in the idle state. A two-entry queue sits ahead of the evaluator.
// Depends on cbspl_pkg, cbspl_front and cbspl_back.
`default_nettype none
module cubic_bspline_point_generator import cbspl_pkg::*; #(
   parameter int COORD_BITS  = 12,
   parameter int T_FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [1:0]            req_mode,
   input  wire logic [COORD_BITS-1:0] req_point_x,
   input  wire logic [COORD_BITS-1:0] req_point_y,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic [COORD_BITS-1:0]      rsp_pixel_x,
   output logic [COORD_BITS-1:0]      rsp_pixel_y,
   output logic                       rsp_status,
   output logic                       rsp_segment_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [1:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   logic [T_FRAC_BITS:0] tstep_ff;
   logic                 qv, qt;
   op_type               qop;
   logic [COORD_BITS-1:0] qx, qy;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:0] == 2'(CSR_T_STEP)) ? 32'(tstep_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tstep_ff <= (T_FRAC_BITS+1)'(TSTEP_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == 2'(CSR_T_STEP)) begin
         tstep_ff <= csr_pwdata[T_FRAC_BITS:0];
      end
   end

   cbspl_front #(.CB(COORD_BITS)) u_front (
      .clock, .reset, .req_push, .req_full, .req_mode, .req_point_x, .req_point_y,
      .q_valid(qv), .q_take(qt), .q_op(qop), .q_x(qx), .q_y(qy)
   );

   cbspl_back #(.CB(COORD_BITS), .TF(T_FRAC_BITS)) u_back (
      .clock, .reset, .t_step(tstep_ff),
      .q_valid(qv), .q_take(qt), .q_op(qop), .q_x(qx), .q_y(qy),
      .rsp_empty, .rsp_pop, .rsp_pixel_x, .rsp_pixel_y, .rsp_status,
      .rsp_segment_last
   );

`ifndef SYNTH
   a_take_valid: assert property (@(posedge clock) disable iff (reset) qt |-> qv)
      else $error("queue taken while empty");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_empty == 1'b0 && !rsp_pop |=> !rsp_empty)
      else $error("result lost");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status |-> !rsp_segment_last)
      else $error("not-ready flagged last");
`endif
endmodule
`default_nettype wire
